// File: hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor block.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int COORD_BITS = 12;
   localparam int CSR_IDX_BITS = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CELL_W = 16;
   localparam int LINE_H = 22;
   localparam int BASE_INSET = 4;
   localparam int TOP_INSET = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEFT_EDGE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_EDGE     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM_LIMIT = 2'd3;

   localparam logic [COORD_BITS-1:0] LEFT_EDGE_RST    = COORD_BITS'(12);
   localparam logic [COORD_BITS-1:0] TOP_EDGE_RST     = COORD_BITS'(40);
   localparam logic [COORD_BITS-1:0] RIGHT_LIMIT_RST  = COORD_BITS'(808);
   localparam logic [COORD_BITS-1:0] BOTTOM_LIMIT_RST = COORD_BITS'(608);
   localparam logic [COORD_BITS-1:0] COLUMN_RST       = COORD_BITS'(14);
   localparam logic [COORD_BITS-1:0] LINE_RST         = COORD_BITS'(42);

   // command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_HOME = 1'b1;

   // control characters
   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
   localparam logic [7:0] CH_LAST_PRINT  = 8'd126;
   localparam logic [6:0] GLYPH_QMARK = 7'd31;
   localparam logic [6:0] GLYPH_SPACE = 7'd0;

   // result actions
   localparam logic [1:0] ACT_GLYPH  = 2'd0;
   localparam logic [1:0] ACT_OPAQUE = 2'd1;
   localparam logic [1:0] ACT_SCROLL = 2'd2;

   typedef struct packed {
      logic       command;
      logic [7:0] character_code;
   } req_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [6:0]            glyph_index;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] left_edge;
      logic [COORD_BITS-1:0] top_edge;
      logic [COORD_BITS-1:0] right_limit;
      logic [COORD_BITS-1:0] bottom_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            count;
      rsp_type               rsp0;
      rsp_type               rsp1;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] line;
   } step_type;

endpackage

// File: hw/rtl/tcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_step
// Cursor update and draw command generation for one request.
// ----------------------------------------------------------------------------
module tcc_step import tcc_pkg::*; (
   input  req_type               req,
   input  cfg_type               cfg,
   input  logic [COORD_BITS-1:0] column,
   input  logic [COORD_BITS-1:0] line,
   output step_type              step
);

   localparam int W = COORD_BITS;

   logic [W-1:0] base;
   logic [W:0]   adv_wide;
   logic [W:0]   top_wide;
   logic [W+1:0] adv_bottom;
   logic         scroll_need;
   logic [W-1:0] line_nl;
   logic [W:0]   col_wide;
   logic [W-1:0] right_room;
   logic         wrap;
   logic [W-1:0] col_back;
   logic [6:0]   glyph;
   rsp_type      scroll_rsp;

   always_comb begin
      base       = cfg.left_edge + W'(BASE_INSET);
      adv_wide   = {1'b0, line} + (W+1)'(LINE_H);
      top_wide   = {1'b0, cfg.top_edge} + (W+1)'(LINE_H);
      adv_bottom = {1'b0, adv_wide} + (W+2)'(LINE_H);
      // scroll only when the region holds more than one line
      scroll_need = ({1'b0, cfg.bottom_limit} > top_wide) &&
                    (adv_bottom > {2'b00, cfg.bottom_limit});
      line_nl    = scroll_need ? line : adv_wide[W-1:0];
      col_wide   = {1'b0, column} + (W+1)'(CELL_W);
      right_room = cfg.right_limit - W'(CELL_W);
      wrap       = (cfg.right_limit >= W'(CELL_W)) && (col_wide > {1'b0, right_room});
      col_back   = column - W'(CELL_W);
      glyph      = (req.character_code >= CH_FIRST_PRINT &&
                    req.character_code <= CH_LAST_PRINT) ?
                   7'(req.character_code - CH_FIRST_PRINT) : GLYPH_QMARK;

      scroll_rsp             = '0;
      scroll_rsp.action      = ACT_SCROLL;
      scroll_rsp.last_result = 1'b1;

      step        = '0;
      step.column = column;
      step.line   = line;

      if (req.command == CMD_HOME) begin
         step.column = base;
         step.line   = cfg.top_edge + W'(TOP_INSET);
      end else begin
         unique case (req.character_code)
            CH_LF: begin
               step.column = base;
               if (scroll_need) begin
                  step.count = 2'd1;
                  step.rsp0  = scroll_rsp;
               end else begin
                  step.line = line_nl;
               end
            end
            CH_CR: begin
               step.column = base;
            end
            CH_BS: begin
               if (column > base) begin
                  step.column           = col_back;
                  step.count            = 2'd1;
                  step.rsp0.action      = ACT_OPAQUE;
                  step.rsp0.glyph_index = GLYPH_SPACE;
                  step.rsp0.pos_x       = col_back;
                  step.rsp0.pos_y       = line;
                  step.rsp0.last_result = 1'b1;
               end
            end
            default: begin
               step.rsp0.action      = ACT_GLYPH;
               step.rsp0.glyph_index = glyph;
               step.rsp0.pos_x       = column;
               step.rsp0.pos_y       = line;
               step.count            = 2'd1;
               step.rsp0.last_result = 1'b1;
               if (wrap) begin
                  step.column = base;
                  if (scroll_need) begin
                     step.count            = 2'd2;
                     step.rsp0.last_result = 1'b0;
                     step.rsp1             = scroll_rsp;
                  end else begin
                     step.line = line_nl;
                  end
               end else begin
                  step.column = col_wide[W-1:0];
               end
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/tcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_queue
// Small result queue: takes up to two results per cycle, hands out one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module tcc_queue import tcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  logic [1:0] push_count,
   input  rsp_type push_rsp0,
   input  rsp_type push_rsp1,
   output logic    room_two,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   output logic [QUEUE_CNT_BITS-1:0] fill
);

   rsp_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_CNT_BITS-1:0] n_push;
   logic pop;

   always_comb begin
      n_push    = push_en ? QUEUE_CNT_BITS'(push_count) : '0;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + n_push - QUEUE_CNT_BITS'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign fill      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_rsp0;
      end
      if (push_en && push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= push_rsp1;
      end
   end

endmodule

// File: hw/rtl/text_console_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor
// Console cursor tracking with glyph draw and scroll command output.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per handshake: a character code or a home
//   command. rsp_* returns draw commands (transparent glyph, opaque space,
//   scroll up), at most two per request, the last one flagged last_result.
//   csr_* writes the region edges; write only while no request is in flight.
// Timing:
//   A request's results go into the result queue when it is taken and reach
//   rsp_* from there. One request is taken per cycle while req_ready is high;
//   the cursor update is combinational logic. Results leave one per cycle while
//   rsp_ready is high; a character that wraps with a scroll gives two results.
// Stall:
//   Results wait in a four-entry queue; req_ready is high while the queue has
//   room for two more results, so requests keep flowing while rsp is stalled
//   until fewer than two entries are free.
// Reset:
//   Synchronous, active high: region registers go to 12/40/808/608, the
//   cursor to column 14, line 42, and the queue empties.
// ----------------------------------------------------------------------------
module text_console_cursor import tcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] line_ff, line_in;
   step_type step;
   logic req_fire;
   logic [QUEUE_CNT_BITS-1:0] fill;

   assign req_fire = req_valid && req_ready;

   tcc_step u_step (
      .req    (req_data),
      .cfg    (cfg_ff),
      .column (column_ff),
      .line   (line_ff),
      .step   (step)
   );

   tcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (req_fire),
      .push_count (step.count),
      .push_rsp0  (step.rsp0),
      .push_rsp1  (step.rsp1),
      .room_two   (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fill       (fill)
   );

   always_comb begin
      cfg_in    = cfg_ff;
      column_in = req_fire ? step.column : column_ff;
      line_in   = req_fire ? step.line : line_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT_EDGE:    cfg_in.left_edge    = csr_wdata;
            CSR_TOP_EDGE:     cfg_in.top_edge     = csr_wdata;
            CSR_RIGHT_LIMIT:  cfg_in.right_limit  = csr_wdata;
            CSR_BOTTOM_LIMIT: cfg_in.bottom_limit = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_edge    <= LEFT_EDGE_RST;
         cfg_ff.top_edge     <= TOP_EDGE_RST;
         cfg_ff.right_limit  <= RIGHT_LIMIT_RST;
         cfg_ff.bottom_limit <= BOTTOM_LIMIT_RST;
         column_ff           <= COLUMN_RST;
         line_ff             <= LINE_RST;
      end else begin
         cfg_ff    <= cfg_in;
         column_ff <= column_in;
         line_ff   <= line_in;
      end
   end

   // queue never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // only a put of a character other than LF, CR and BS can produce two results
   a_two_only_print: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step.count == 2'd2) |->
      (req_data.command == CMD_PUT && req_data.character_code != CH_LF &&
       req_data.character_code != CH_CR && req_data.character_code != CH_BS))
      else $error("two results from a non-printable request");

   // scroll commands carry no position and always close a request
   a_scroll_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action == ACT_SCROLL) |->
      (rsp_data.last_result && rsp_data.pos_x == '0 && rsp_data.pos_y == '0))
      else $error("malformed scroll result");

   // home moves the cursor to the region start
   a_home: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_HOME) |=>
      (column_ff == $past(cfg_ff.left_edge + COORD_BITS'(BASE_INSET)) &&
       line_ff == $past(cfg_ff.top_edge + COORD_BITS'(TOP_INSET))))
      else $error("home did not reach region start");

endmodule
